FILE: hdl/mt19937_generator_defines.svh
// ----------------------------------------------------------------------------
// mt19937_generator_defines.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef MT19937_GENERATOR_DEFINES_SVH
`define MT19937_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define MTG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("mt19937 check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define MTG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mt19937 check failed");

`endif

FILE: hdl/mtg_pkg.sv
// ----------------------------------------------------------------------------
// mtg_pkg
// Types, constants and tempering function of the MT19937 generator.
// ----------------------------------------------------------------------------
package mtg_pkg;

  localparam int STATE_WORDS_DEF = 624;
  localparam int SHIFT_M         = 397;
  localparam int WORD_W          = 32;
  localparam int VALUE_W         = 53;
  localparam int SEED_W          = 64;

  localparam logic [31:0] MT_MATRIX   = 32'h9908b0df;
  localparam logic [31:0] MT_UPPER    = 32'h80000000;
  localparam logic [31:0] MT_LOWER    = 32'h7fffffff;
  localparam logic [31:0] MT_INIT_MUL = 32'd1812433253;
  localparam logic [31:0] MT_DEF_SEED = 32'd5489;
  localparam logic [31:0] MT_TEMPER_B = 32'h9d2c5680;
  localparam logic [31:0] MT_TEMPER_C = 32'hefc60000;

  typedef enum logic [1:0] {
    CMD_SEED    = 2'd0,
    CMD_RAW     = 2'd1,
    CMD_BOUNDED = 2'd2,
    CMD_UNIT    = 2'd3
  } cmd_t;

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] v;
    v = w ^ (w >> 11);
    v = v ^ ((v << 7) & MT_TEMPER_B);
    v = v ^ ((v << 15) & MT_TEMPER_C);
    v = v ^ (v >> 18);
    return v;
  endfunction

endpackage

FILE: hdl/mt19937_generator.sv
// ----------------------------------------------------------------------------
// mt19937_generator
// MT19937 32-bit generator: seed, raw, bounded and 53-bit fraction draws.
// ----------------------------------------------------------------------------
//  channel  | signals                 | handshake
//  ---------+-------------------------+--------------------------------
//  command  | cmd, seed, bound        | taken when start & !busy
//  result   | value                   | done high one cycle, no stall
//
// Raw draw: read request, temper, result register.
// Every 624th word a twist runs first, rewriting the state one word at a time
//   through the single write port of the state memory.
// Seed: each word takes a multiply step, then an add/write step.
// Bounded draw first finds the threshold, then the remainder of each accepted
//   word, both in the shared bit-serial divider; rejects redraw.
// Unit draw takes two raw words. Bound of zero answers the next cycle.
// Synchronous reset leaves the memory untouched; a draw before any seed seeds it.
// ----------------------------------------------------------------------------
module mt19937_generator #(
  parameter int STATE_WORDS = mtg_pkg::STATE_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  mtg_pkg::cmd_t                 cmd,
  input  logic [mtg_pkg::SEED_W-1:0]    seed,
  input  logic [mtg_pkg::WORD_W-1:0]    bound,
  output logic                          done,
  output logic [mtg_pkg::VALUE_W-1:0]   value
);
  import mtg_pkg::*;

  localparam int AW = $clog2(STATE_WORDS);
  localparam int PW = $clog2(STATE_WORDS + 1);
  localparam logic [PW-1:0] POS_END  = PW'(STATE_WORDS);
  localparam logic [AW-1:0] IDX_LAST = AW'(STATE_WORDS - 1);
  localparam logic [AW-1:0] FAR_LIM  = AW'(STATE_WORDS - SHIFT_M);
  localparam logic [AW-1:0] OFS_M    = AW'(SHIFT_M);
  localparam logic [AW-1:0] OFS_BACK = AW'(STATE_WORDS - SHIFT_M);

  typedef enum logic [11:0] {
    ST_IDLE    = 12'b000000000001,
    ST_SEED0   = 12'b000000000010,
    ST_SD_MUL  = 12'b000000000100,
    ST_SD_WR   = 12'b000000001000,
    ST_TW_LOAD = 12'b000000010000,
    ST_TW_HOLD = 12'b000000100000,
    ST_TW_RD   = 12'b000001000000,
    ST_TW_WR   = 12'b000010000000,
    ST_DR_RD   = 12'b000100000000,
    ST_DR_TEMP = 12'b001000000000,
    ST_DIV_THR = 12'b010000000000,
    ST_DIV_MOD = 12'b100000000000
  } state_t;

  state_t        state;
  cmd_t          cmd_r;
  logic [31:0]   bound_r;
  logic [31:0]   seed_w;
  logic          seeded;
  logic [PW-1:0] pos;
  logic [AW-1:0] idx;
  logic [31:0]   prev;
  logic [31:0]   prod;
  logic [31:0]   cur;
  logic [26:0]   hi;
  logic          half;
  logic [31:0]   thr;

  // memory hookup
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [AW-1:0] raddr_a;
  logic [AW-1:0] raddr_b;
  logic [31:0]   rdata_a;
  logic [31:0]   rdata_b;

  // divider hookup
  logic          div_go;
  logic [31:0]   div_dvd;
  logic [31:0]   div_dsr;
  logic          div_done;
  logic [31:0]   div_rem;

  logic [31:0]   mul_lo;
  logic [31:0]   seed_next;
  logic [31:0]   tw_y;
  logic [31:0]   tw_w;
  logic [31:0]   tempered;
  logic [AW-1:0] idx_nxt;
  logic [AW-1:0] idx_far;

  mtg_store #(.DEPTH(STATE_WORDS), .AW(AW)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr_a(raddr_a), .raddr_b(raddr_b),
    .rdata_a(rdata_a), .rdata_b(rdata_b)
  );

  mtg_divider u_div (
    .clk(clk), .rst(rst), .go(div_go), .dividend(div_dvd),
    .divisor(div_dsr), .done(div_done), .remainder(div_rem)
  );

  assign busy      = (state != ST_IDLE);
  assign mul_lo    = MT_INIT_MUL * (prev ^ (prev >> 30));
  assign seed_next = prod + 32'(idx);
  assign idx_nxt   = (idx == IDX_LAST) ? '0 : idx + AW'(1);
  assign idx_far   = (idx < FAR_LIM) ? idx + OFS_M : idx - OFS_BACK;
  assign tw_y      = (cur & MT_UPPER) | (rdata_a & MT_LOWER);
  assign tw_w      = rdata_b ^ (tw_y >> 1) ^ (tw_y[0] ? MT_MATRIX : 32'd0);
  assign tempered  = temper(rdata_a);

  // memory port and divider control
  always_comb begin
    we      = 1'b0;
    waddr   = idx;
    wdata   = seed_next;
    raddr_a = '0;
    raddr_b = idx_far;
    div_go  = 1'b0;
    div_dvd = tempered;
    div_dsr = bound_r;
    unique case (state)
      ST_SEED0: begin
        we    = 1'b1;
        waddr = '0;
        wdata = seed_w;
      end
      ST_SD_WR: we = 1'b1;
      ST_TW_RD: raddr_a = idx_nxt;
      ST_TW_WR: begin
        we    = 1'b1;
        wdata = tw_w;
      end
      ST_DR_RD: raddr_a = pos[AW-1:0];
      ST_DR_TEMP: div_go = (cmd_r == CMD_BOUNDED) && !(tempered < thr);
      ST_IDLE: begin
        div_go  = start && (cmd == CMD_BOUNDED) && (bound != 32'd0);
        div_dvd = 32'd0 - bound;
        div_dsr = bound;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      seeded <= 1'b0;
      pos    <= POS_END;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            cmd_r   <= cmd;
            bound_r <= bound;
            seed_w  <= seed[31:0] ^ seed[63:32];
            half    <= 1'b0;
            if (cmd == CMD_SEED) begin
              state <= ST_SEED0;
            end else if (cmd == CMD_BOUNDED) begin
              if (bound == 32'd0) begin
                value <= '0;
                done  <= 1'b1;
              end else begin
                state <= ST_DIV_THR;
              end
            end else begin
              state <= ST_DR_RD;
            end
          end
        end
        ST_SEED0: begin
          prev  <= seed_w;
          idx   <= AW'(1);
          state <= ST_SD_MUL;
        end
        ST_SD_MUL: begin
          prod  <= mul_lo;
          state <= ST_SD_WR;
        end
        ST_SD_WR: begin
          prev <= seed_next;
          if (idx == IDX_LAST) begin
            pos    <= POS_END;
            seeded <= 1'b1;
            state  <= (cmd_r == CMD_SEED) ? ST_IDLE : ST_DR_RD;
          end else begin
            idx   <= idx + AW'(1);
            state <= ST_SD_MUL;
          end
        end
        ST_TW_LOAD: state <= ST_TW_HOLD;   // read of word 0 in flight
        ST_TW_HOLD: begin
          cur   <= rdata_a;
          state <= ST_TW_RD;
        end
        ST_TW_RD: state <= ST_TW_WR;
        ST_TW_WR: begin
          cur <= rdata_a;
          if (idx == IDX_LAST) begin
            pos   <= '0;
            state <= ST_DR_RD;
          end else begin
            idx   <= idx + AW'(1);
            state <= ST_TW_RD;
          end
        end
        ST_DR_RD: begin
          if (!seeded) begin
            seed_w <= MT_DEF_SEED;
            state  <= ST_SEED0;
          end else if (pos >= POS_END) begin
            idx   <= '0;
            state <= ST_TW_LOAD;
          end else begin
            pos   <= pos + PW'(1);
            state <= ST_DR_TEMP;
          end
        end
        ST_DR_TEMP: begin
          unique case (cmd_r)
            CMD_UNIT: begin
              if (!half) begin
                hi    <= tempered[31:5];
                half  <= 1'b1;
                state <= ST_DR_RD;
              end else begin
                value <= {hi, tempered[31:6]};
                done  <= 1'b1;
                state <= ST_IDLE;
              end
            end
            CMD_BOUNDED: begin
              // reject below threshold, else remainder in the divider
              state <= (tempered < thr) ? ST_DR_RD : ST_DIV_MOD;
            end
            default: begin
              value <= VALUE_W'(tempered);
              done  <= 1'b1;
              state <= ST_IDLE;
            end
          endcase
        end
        ST_DIV_THR: begin
          if (div_done) begin
            thr   <= div_rem;
            state <= ST_DR_RD;
          end
        end
        ST_DIV_MOD: begin
          if (div_done) begin
            value <= VALUE_W'(div_rem);
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

FILE: hdl/mtg_store.sv
// ----------------------------------------------------------------------------
// mtg_store
// State word memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module mtg_store #(
  parameter int DEPTH = mtg_pkg::STATE_WORDS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [31:0]   rdata_a,
  output logic [31:0]   rdata_b
);
  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

FILE: hdl/mtg_divider.sv
// ----------------------------------------------------------------------------
// mtg_divider
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mtg_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] remainder
);
  logic [31:0] rem;
  logic [31:0] dvd;
  logic [31:0] dsr;
  logic [5:0]  cnt;
  logic        run;
  logic [32:0] trial;

  assign trial     = {rem, dvd[31]};
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= 6'd32;
        rem <= '0;
        dvd <= dividend;
        dsr <= divisor;
      end else if (run) begin
        if (trial >= {1'b0, dsr}) begin
          rem <= 32'(trial - {1'b0, dsr});
        end else begin
          rem <= trial[31:0];
        end
        dvd <= dvd << 1;
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: hdl/mtg_checker.sv
// ----------------------------------------------------------------------------
// mtg_checker
// Port-level checks of the MT19937 generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "mt19937_generator_defines.svh"

module mtg_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  cmd,
  input logic        done
);
  import mtg_pkg::*;

  // a word is only presented once the sequencer is back at rest
  `MTG_ASSERT_NOW(a_done_idle, !rst && done, !busy)
  // reset leaves the block idle with no word pending
  `MTG_ASSERT_NEXT(a_rst_clear, rst, !busy && !done)
  // seeding walks the whole store, so it never ends at once
  `MTG_ASSERT_NEXT(a_seed_busy, !rst && start && !busy && (cmd == CMD_SEED), busy && !done)
  // a raw draw needs at least a memory read before its word
  `MTG_ASSERT_NEXT(a_raw_busy, !rst && start && !busy && (cmd == CMD_RAW), busy && !done)
endmodule

bind mt19937_generator mtg_checker u_mtg_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .done(done)
);

FILE: dv/mt19937_generator_tb.sv
// ----------------------------------------------------------------------------
// mt19937_generator_tb
// Self-checking bench for the MT19937 generator: a queued command driver,
// a done-strobe monitor and a predictor that models the store step by step.
// ----------------------------------------------------------------------------
module mt19937_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mtg_pkg::*;

  localparam int NWORDS     = 624;
  localparam int WDOG_LIMIT = 40000;   // worst case: seed/twist + bounded redraws
  localparam int RAND_ITEMS = 1800;

  typedef struct packed {
    cmd_t        op;
    logic [63:0] seed_v;
    logic [31:0] bound_v;
  } word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  cmd_t        cmd = CMD_SEED;
  logic [63:0] seed = '0;
  logic [31:0] bound = '0;
  logic        busy, done;
  logic [52:0] value;

  mt19937_generator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .seed(seed), .bound(bound), .done(done), .value(value)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [31:0] mt_store [NWORDS];
  int          rd_pos = NWORDS;
  bit          is_seeded = 0;

  word_t       pending_q [$];
  logic [52:0] expected_q [$];
  int          n_errors = 0;
  int          idle_pct = 0;   // sender idle chance, percent

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  function automatic void seed_store(input logic [63:0] s);
    mt_store[0] = s[31:0] ^ s[63:32];
    for (int i = 1; i < NWORDS; i++)
      mt_store[i] = MT_INIT_MUL * (mt_store[i-1] ^ (mt_store[i-1] >> 30)) + 32'(i);
    rd_pos = NWORDS;
    is_seeded = 1;
  endfunction

  function automatic logic [31:0] next_raw();
    logic [31:0] y, w, v;
    if (!is_seeded) seed_store(64'(MT_DEF_SEED));
    if (rd_pos >= NWORDS) begin
      for (int i = 0; i < NWORDS; i++) begin
        y = (mt_store[i] & MT_UPPER) | (mt_store[(i+1)%NWORDS] & MT_LOWER);
        w = mt_store[(i+SHIFT_M)%NWORDS] ^ (y >> 1);
        if (y[0]) w ^= MT_MATRIX;
        mt_store[i] = w;
      end
      rd_pos = 0;
    end
    v = mt_store[rd_pos];
    rd_pos++;
    v ^= v >> 11;
    v ^= (v << 7) & MT_TEMPER_B;
    v ^= (v << 15) & MT_TEMPER_C;
    v ^= v >> 18;
    return v;
  endfunction

  // Work out the word the block should answer; seeds give nothing.
  function automatic void predict_word(input word_t it);
    logic [31:0] thr, v;
    logic [63:0] hi, lo;
    case (it.op)
      CMD_SEED: seed_store(it.seed_v);
      CMD_RAW:  expected_q.push_back(53'(next_raw()));
      CMD_BOUNDED: begin
        if (it.bound_v == 0) expected_q.push_back('0);
        else begin
          thr = (32'd0 - it.bound_v) % it.bound_v;
          do v = next_raw(); while (v < thr);
          expected_q.push_back(53'(v % it.bound_v));
        end
      end
      default: begin
        hi = 64'(next_raw() >> 5);
        lo = 64'(next_raw() >> 6);
        expected_q.push_back(53'(hi * 64'd67108864 + lo));
      end
    endcase
  endfunction

  // Driver: a waiting command is held; otherwise the sender idles per cycle.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        predict_word(word_t'{cmd, seed, bound});
        void'(pending_q.pop_front());
      end
      if (!(start && busy)) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          start <= 1'b1;
          cmd   <= pending_q[0].op;
          seed  <= pending_q[0].seed_v;
          bound <= pending_q[0].bound_v;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: done is a one-cycle strobe, compared against the oldest word.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_q.size() == 0)
        report($sformatf("unexpected value %h", value));
      else if (value !== expected_q[0])
        report($sformatf("value %h, expected %h", value, expected_q.pop_front()));
      else
        void'(expected_q.pop_front());
    end
  end

  // Watchdog: cycles with nothing accepted on either side.
  int quiet = 0;
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WDOG_LIMIT) begin
      $display("mt19937_generator_tb: errors");
      $finish;
    end
  end

  function automatic word_t mk(input cmd_t op, input logic [63:0] s,
                               input logic [31:0] b);
    return '{op, s, b};
  endfunction

  // Small bounds and bounds near 2^31 and 2^32 are favoured so rejection and modulo paths get stressed.
  function automatic logic [31:0] rand_bound();
    case ($urandom_range(5))
      0: return 32'($urandom_range(3));
      1: return 32'h8000_0000 + 32'($urandom_range(7));
      2: return 32'hffff_ffff - 32'($urandom_range(3));
      3: return 32'($urandom_range(1000));
      default: return $urandom;
    endcase
  endfunction

  task automatic drain();
    while (pending_q.size() > 0 || expected_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    cmd_t op;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // draw before any seed: default seed path
    pending_q.push_back(mk(CMD_RAW, '0, '0));
    pending_q.push_back(mk(CMD_UNIT, '0, '0));
    pending_q.push_back(mk(CMD_BOUNDED, '0, 32'd0));
    pending_q.push_back(mk(CMD_BOUNDED, '0, 32'd1));
    pending_q.push_back(mk(CMD_BOUNDED, '0, 32'hffff_ffff));
    pending_q.push_back(mk(CMD_BOUNDED, '0, 32'h8000_0001));
    pending_q.push_back(mk(CMD_SEED, 64'hffff_ffff_ffff_ffff, '0));
    pending_q.push_back(mk(CMD_RAW, '0, '0));
    pending_q.push_back(mk(CMD_SEED, 64'h0, '0));
    pending_q.push_back(mk(CMD_SEED, 64'hffff_ffff_0000_0000, '0));
    pending_q.push_back(mk(CMD_RAW, '0, '0));
    pending_q.push_back(mk(CMD_UNIT, '0, '0));
    pending_q.push_back(mk(CMD_BOUNDED, '0, 32'd3));
    pending_q.push_back(mk(CMD_SEED, 64'd5489, '0));
    pending_q.push_back(mk(CMD_RAW, '0, '0));
    drain();
    // random phases: none, 68% sender idle, 29% sender idle
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 1) ? 68 : 29;
      for (int i = 0; i < RAND_ITEMS / 3; i++) begin
        case ($urandom_range(19))
          0: op = CMD_SEED;
          1, 2, 3, 4, 5, 6, 7: op = CMD_RAW;
          8, 9, 10, 11, 12, 13: op = CMD_BOUNDED;
          default: op = CMD_UNIT;
        endcase
        pending_q.push_back(mk(op, {$urandom, $urandom}, rand_bound()));
        if (i % 50 == 49) while (pending_q.size() > 8) @(posedge clk);
      end
      drain();
    end
    if (n_errors == 0)
      $display("mt19937_generator_tb: clean");
    else
      $display("mt19937_generator_tb: errors");
    $finish;
  end
endmodule
